// ===== rtl/core/rate_limited_bearing_tracker_defines.svh =====
// assertion macros for the bearing tracker checker
// no dependencies; included by rlbt_checker.sv
`ifndef RATE_LIMITED_BEARING_TRACKER_DEFINES_SVH
`define RATE_LIMITED_BEARING_TRACKER_DEFINES_SVH

// next-cycle implication, disabled while reset is high
`define RLBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds through reset
`define RLBT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rlbt_pkg.sv =====
// shared types, constants and microcode for the bearing tracker
// no dependencies; used by all rtl modules of the block
package rlbt_pkg;

   // item widths on the stream ports
   localparam int unsigned REQ_DATA_W = 80;
   localparam int unsigned RSP_DATA_W = 16;

   // cordic datapath width (covers 17-bit delta << 16 with growth)
   localparam int unsigned CORDIC_XW = 36;

   // arctan table: atan(2^-i) as a fraction of a turn, scaled by 2^32
   localparam int unsigned ATAN_LEN   = 24;
   localparam int unsigned ATAN_IDX_W = 5;
   localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // binary angles
   localparam logic [15:0] ANGLE_ZERO     = 16'd0;
   localparam logic [15:0] ANGLE_QUARTER  = 16'd16384;
   localparam logic [15:0] ANGLE_HALF     = 16'd32768;
   localparam logic [15:0] ANGLE_3QUARTER = 16'd49152;

   // turn rate after reset (about 250 degrees per second)
   localparam logic [15:0] TURN_RATE_RESET = 16'd45511;

   // microcode program counter
   localparam int unsigned PC_W      = 3;
   localparam int unsigned UCODE_LEN = 8;
   typedef logic [PC_W-1:0] pc_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DELTA,
      OP_SETUP,
      OP_ROTATE,
      OP_ROUND,
      OP_DIFF,
      OP_UPDATE,
      OP_NOP
   } op_type;

   // sequencing conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_WAIT_IN,
      COND_WAIT_OUT,
      COND_IF_INVALID,
      COND_IF_AXIS,
      COND_IF_MORE,
      COND_ALWAYS
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // flags from the datapath to the sequencer
   typedef struct packed {
      logic target_invalid;
      logic on_axis;
      logic more_steps;
      logic out_busy;
   } dp_status_type;

   // program step addresses
   localparam pc_type STEP_LOAD   = 3'd0;
   localparam pc_type STEP_DELTA  = 3'd1;
   localparam pc_type STEP_SETUP  = 3'd2;
   localparam pc_type STEP_ROTATE = 3'd3;
   localparam pc_type STEP_ROUND  = 3'd4;
   localparam pc_type STEP_DIFF   = 3'd5;
   localparam pc_type STEP_UPDATE = 3'd6;
   localparam pc_type STEP_RETURN = 3'd7;

   // control program, one word per step
   localparam ctrl_word_type UCODE [UCODE_LEN] = '{
      '{OP_LOAD,   COND_WAIT_IN,    STEP_LOAD},
      '{OP_DELTA,  COND_IF_INVALID, STEP_UPDATE},
      '{OP_SETUP,  COND_IF_AXIS,    STEP_DIFF},
      '{OP_ROTATE, COND_IF_MORE,    STEP_ROTATE},
      '{OP_ROUND,  COND_NEXT,       STEP_DIFF},
      '{OP_DIFF,   COND_NEXT,       STEP_UPDATE},
      '{OP_UPDATE, COND_WAIT_OUT,   STEP_RETURN},
      '{OP_NOP,    COND_ALWAYS,     STEP_LOAD}
   };

endpackage

// ===== rtl/core/rate_limited_bearing_tracker.sv =====
// rate limited bearing tracker: one item in, one result out, cordic atan2 inside.
// steps per item: load, delta, setup, the cordic rotations, round, diff and update for an
// off-axis target; an axis target skips rotations and round, an invalid one goes from delta to update.
// one item at a time: the next item is taken only after the last has passed its update; the pace
// is set by the shift-add cordic loop; a waiting result does not block the next item until its update.
// reset: synchronous, heading 0, turn_rate 45511, no result pending.
module rate_limited_bearing_tracker #(
   parameter int unsigned ANGLE_BITS   = 16,
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // own_x[15:0], own_y[31:16], target_x[47:32], target_y[63:48], time_step[79:64]
   input  logic [rlbt_pkg::REQ_DATA_W-1:0] req_tdata,
   // target_valid[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // heading[15:0]
   output logic [rlbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // on_target[0]
   output logic                            rsp_tuser,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data
);
   import rlbt_pkg::*;

   ctrl_word_type ctrl;
   dp_status_type status;
   logic          op_fire;

   // item taken only in the load step, never while in reset
   assign req_tready = (ctrl.op == OP_LOAD) && !reset;

   rlbt_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .status    (status),
      .ctrl      (ctrl),
      .op_fire   (op_fire)
   );

   rlbt_datapath #(
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (ctrl.op),
      .op_fire     (op_fire),
      .req_data    (req_tdata),
      .req_user    (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_tready),
      .status      (status),
      .rsp_valid   (rsp_tvalid),
      .rsp_data    (rsp_tdata),
      .rsp_user    (rsp_tuser)
   );

endmodule

// ===== rtl/core/rlbt_sequencer.sv =====
// microcode sequencer: step counter, control rom and jump logic
// depends on rlbt_pkg
module rlbt_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  rlbt_pkg::dp_status_type status,
   output rlbt_pkg::ctrl_word_type ctrl,
   output logic                   op_fire
);
   import rlbt_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   logic   hold;
   logic   jump;

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // fetch, condition test and next step
   always_comb begin
      ctrl = UCODE[pc_ff];
      hold = 1'b0;
      jump = 1'b0;
      case (ctrl.cond)
         COND_NEXT:       jump = 1'b0;
         COND_WAIT_IN:    hold = !req_valid;
         COND_WAIT_OUT:   hold = status.out_busy;
         COND_IF_INVALID: jump = status.target_invalid;
         COND_IF_AXIS:    jump = status.on_axis;
         COND_IF_MORE:    jump = status.more_steps;
         COND_ALWAYS:     jump = 1'b1;
         default:         jump = 1'b0;
      endcase
      op_fire = !hold;
      if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_type'(pc_ff + 1'b1);
      end
   end

endmodule

// ===== rtl/core/rlbt_datapath.sv =====
// datapath: input latch, cordic shift-add unit, turn limiter, result register
// depends on rlbt_pkg; driven by rlbt_sequencer
module rlbt_datapath #(
   parameter int unsigned ANGLE_BITS   = 16,
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rlbt_pkg::op_type                  op,
   input  logic                              op_fire,
   input  logic [rlbt_pkg::REQ_DATA_W-1:0]   req_data,
   input  logic                              req_user,
   input  logic                              csr_wr_en,
   input  logic [15:0]                       csr_wr_data,
   input  logic                              rsp_ready,
   output rlbt_pkg::dp_status_type           status,
   output logic                              rsp_valid,
   output logic [rlbt_pkg::RSP_DATA_W-1:0]   rsp_data,
   output logic                              rsp_user
);
   import rlbt_pkg::*;

   localparam int unsigned ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int unsigned RND_W  = ANGLE_BITS + 17;
   localparam logic [32:0] ATAN_ROUND = 33'd1 << (31 - ANGLE_BITS);
   localparam logic [ANGLE_BITS-1:0] Z_HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   // latched item
   logic signed [15:0] own_x_ff, own_y_ff, target_x_ff, target_y_ff;
   logic               valid_ff;
   logic [15:0]        time_step_ff;

   // working registers
   logic signed [16:0]          dx_ff, dy_ff;
   logic [31:0]                 prod_ff;
   logic signed [CORDIC_XW-1:0] x_ff, y_ff, x_in, y_in;
   logic [ANGLE_BITS-1:0]       z_ff, z_in;
   logic [ITER_W-1:0]           iter_ff;
   logic [15:0]                 bear_ff, bear_in;
   logic [15:0]                 diff_ff, limit_ff;
   logic [15:0]                 head_ff, head_in;
   logic                        on_in;
   logic [15:0]                 turn_rate_ff;
   logic                        rsp_valid_ff;
   logic [15:0]                 rsp_heading_ff;
   logic                        rsp_on_ff;

   // cordic helpers
   logic signed [CORDIC_XW-1:0] x_init, xs, ys;
   logic [ATAN_IDX_W-1:0]       atan_idx;
   logic [32:0]                 atan_sum;
   logic [ANGLE_BITS-1:0]       atan_step;
   logic [RND_W-1:0]            z_wide;
   logic                        on_axis;
   logic [15:0]                 axis_bear;

   // turn limiter helpers
   logic        positive;
   logic [15:0] mag;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         turn_rate_ff <= TURN_RATE_RESET;
      end else if (csr_wr_en) begin
         turn_rate_ff <= csr_wr_data;
      end
   end

   // axis cases bypass the iteration
   always_comb begin
      on_axis = (dx_ff == 17'sd0) || (dy_ff == 17'sd0);
      if (dy_ff == 17'sd0) begin
         axis_bear = dx_ff[16] ? ANGLE_HALF : ANGLE_ZERO;
      end else begin
         axis_bear = dy_ff[16] ? ANGLE_3QUARTER : ANGLE_QUARTER;
      end
   end

   // one cordic vectoring step
   always_comb begin
      x_init    = {{(CORDIC_XW-33){dx_ff[16]}}, dx_ff, 16'h0000};
      xs        = x_ff >>> iter_ff;
      ys        = y_ff >>> iter_ff;
      atan_idx  = ATAN_IDX_W'(iter_ff);
      atan_sum  = {1'b0, ATAN_TURN32[atan_idx]} + ATAN_ROUND;
      atan_step = ANGLE_BITS'(atan_sum >> (32 - ANGLE_BITS));
      if (y_ff > 0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_step;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_step;
      end
      z_wide  = {1'b0, z_ff, 16'h0000} + RND_W'(Z_HALF);
      bear_in = z_wide[ANGLE_BITS+15:ANGLE_BITS];
   end

   // signed difference, snap or step toward the bearing, hold the heading for an invalid target
   always_comb begin
      positive = (diff_ff != 16'd0) && (diff_ff <= ANGLE_HALF);
      mag      = positive ? diff_ff : 16'(~diff_ff + 16'd1);
      head_in  = head_ff;
      on_in    = 1'b0;
      if (valid_ff) begin
         if (mag < limit_ff) begin
            head_in = bear_ff;
            on_in   = 1'b1;
         end else if (diff_ff != 16'd0) begin
            head_in = positive ? 16'(head_ff + limit_ff) : 16'(head_ff - limit_ff);
         end
      end
   end

   // heading state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 16'd0;
      end else if (op_fire && (op == OP_UPDATE)) begin
         head_ff <= head_in;
      end
   end

   // working registers, one operation per step
   always_ff @(posedge clock) begin
      if (op_fire) begin
         case (op)
            OP_LOAD: begin
               own_x_ff     <= req_data[15:0];
               own_y_ff     <= req_data[31:16];
               target_x_ff  <= req_data[47:32];
               target_y_ff  <= req_data[63:48];
               time_step_ff <= req_data[79:64];
               valid_ff     <= req_user;
            end
            OP_DELTA: begin
               dx_ff   <= 17'(target_x_ff) - 17'(own_x_ff);
               dy_ff   <= 17'(target_y_ff) - 17'(own_y_ff);
               prod_ff <= turn_rate_ff * time_step_ff;
            end
            OP_SETUP: begin
               iter_ff <= '0;
               if (on_axis) begin
                  bear_ff <= axis_bear;
               end else if (dx_ff[16]) begin
                  x_ff <= -x_init;
                  y_ff <= -{{(CORDIC_XW-33){dy_ff[16]}}, dy_ff, 16'h0000};
                  z_ff <= Z_HALF;
               end else begin
                  x_ff <= x_init;
                  y_ff <= {{(CORDIC_XW-33){dy_ff[16]}}, dy_ff, 16'h0000};
                  z_ff <= '0;
               end
            end
            OP_ROTATE: begin
               x_ff    <= x_in;
               y_ff    <= y_in;
               z_ff    <= z_in;
               iter_ff <= ITER_W'(iter_ff + 1'b1);
            end
            OP_ROUND: begin
               bear_ff <= bear_in;
            end
            OP_DIFF: begin
               diff_ff  <= 16'(bear_ff - head_ff);
               limit_ff <= (prod_ff[31:16] > ANGLE_HALF) ? ANGLE_HALF : prod_ff[31:16];
            end
            default: begin
               valid_ff <= valid_ff;
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op_fire && (op == OP_UPDATE)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (op_fire && (op == OP_UPDATE)) begin
         rsp_heading_ff <= head_in;
         rsp_on_ff      <= on_in;
      end
   end

   // status to the sequencer and outputs
   always_comb begin
      status.target_invalid = !valid_ff;
      status.on_axis        = on_axis;
      status.more_steps     = (iter_ff != ITER_LAST);
      status.out_busy       = rsp_valid_ff && !rsp_ready;
      rsp_valid             = rsp_valid_ff;
      rsp_data              = rsp_heading_ff;
      rsp_user              = rsp_on_ff;
   end

endmodule

// ===== rtl/core/rlbt_checker.sv =====
// port-level checks for the bearing tracker, bound to the top level
// depends on rlbt_pkg and rate_limited_bearing_tracker_defines.svh
`include "rate_limited_bearing_tracker_defines.svh"

module rlbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rlbt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // one item at a time: the block is busy right after taking an item
   `RLBT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while previous one in work")

   // reset leaves no result pending
   `RLBT_ASSERT_NEXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_tvalid, "result valid after reset")

   // a stalled result holds
   `RLBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind rate_limited_bearing_tracker rlbt_checker u_rlbt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
